/* hdl/ookd_pkg.sv */
// Shared types and constants for the on-off-keyed pulse frame decoder.
`default_nettype none

package ookd_pkg;

  localparam int MAX_PULSES = 511;
  localparam int CNT_W      = $clog2(MAX_PULSES + 1);
  localparam int GRP_W      = CNT_W - 2;
  localparam int PULSE_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int WORD_W     = 36;
  localparam int SNAP_W     = 32;
  localparam int BAD_W      = 6;

  localparam int BITS_PLAIN = 32;
  localparam int BITS_DIM   = 36;
  localparam int MIN_TOTAL  = 4;
  localparam int PREAMBLE_PULSES = 2;

  localparam logic [BAD_W-1:0] NO_BAD_GROUP = '1;

  localparam logic [PULSE_W-1:0] RST_SHORT_MIN    = 8'd2;
  localparam logic [PULSE_W-1:0] RST_SHORT_MAX    = 8'd7;
  localparam logic [PULSE_W-1:0] RST_LONG_MIN     = 8'd17;
  localparam logic [PULSE_W-1:0] RST_LONG_MAX     = 8'd27;
  localparam logic [PULSE_W-1:0] RST_PREAMBLE_MIN = 8'd40;
  localparam logic [PULSE_W-1:0] RST_PREAMBLE_MAX = 8'd48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_MIN    = 3'd0,
    REG_SHORT_MAX    = 3'd1,
    REG_LONG_MIN     = 3'd2,
    REG_LONG_MAX     = 3'd3,
    REG_PREAMBLE_MIN = 3'd4,
    REG_PREAMBLE_MAX = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [PULSE_W-1:0] short_min;
    logic [PULSE_W-1:0] short_max;
    logic [PULSE_W-1:0] long_min;
    logic [PULSE_W-1:0] long_max;
    logic [PULSE_W-1:0] preamble_min;
    logic [PULSE_W-1:0] preamble_max;
  } cfg_t;

  typedef struct packed {
    logic in_short;
    logic is_long;
    logic is_preamble;
  } cls_t;

endpackage

`default_nettype wire

/* hdl/ookd_classify.sv */
// Pulse length classifier against the short, long and preamble windows.
`default_nettype none

module ookd_classify (
  input  wire logic [ookd_pkg::PULSE_W-1:0] pulse,
  input  wire ookd_pkg::cfg_t               cfg,
  output ookd_pkg::cls_t                    cls
);
  import ookd_pkg::*;

  always_comb begin
    cls.in_short    = (pulse >= cfg.short_min) && (pulse <= cfg.short_max);
    cls.is_long     = (pulse >= cfg.long_min) && (pulse <= cfg.long_max);
    cls.is_preamble = (pulse >= cfg.preamble_min) && (pulse <= cfg.preamble_max);
  end

endmodule

`default_nettype wire

/* hdl/ook_pulse_frame_decoder.sv */
// Top level of the on-off-keyed pulse frame decoder with output register.
// A result is registered on the transfer of the last pulse and is valid in the cycle after it.
// Throughput: one pulse per cycle; the frame state updates in a single pass.
// A result held off by the receiver stalls the input until its transfer.
// Reset (synchronous, active high) clears the frame state, empties the
// output register and restores the default pulse windows.
`default_nettype none

module ook_pulse_frame_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ookd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ookd_pkg::PULSE_W-1:0]      cfg_wdata,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,  // [7:0] pulse_length
  input  wire logic                              s_tlast,  // last_pulse
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [39:0]                            m_tdata,  // [35:0] data_word, [39:36] 0
  output logic [1:0]                             m_tuser   // [0] accepted, [1] dim_present
);
  import ookd_pkg::*;

  cfg_t cfg;

  logic [CNT_W-1:0]   pulse_count, pulse_count_next;
  logic [PULSE_W-1:0] first_preamble_pulse, first_preamble_pulse_next;
  logic               preamble_ok, preamble_ok_next;
  logic [PULSE_W-1:0] group_pulses [3];
  logic [PULSE_W-1:0] group_pulses_next [3];
  logic [WORD_W-1:0]  bit_shift, bit_shift_next;
  logic [SNAP_W-1:0]  snapshot_32, snapshot_32_next;
  logic [BAD_W-1:0]   first_bad_group, first_bad_group_next;

  logic               s_accept;
  logic [PULSE_W-1:0] pulse;
  cls_t               cls_pulse, cls_first, cls_g0, cls_g1, cls_g2;

  logic [CNT_W-1:0]   j;
  logic [1:0]         pos;
  logic [GRP_W-1:0]   grp;
  logic               bit_one, bit_zero;

  logic [CNT_W-1:0]   n_bits;
  logic               res_ok, res_dim;
  logic [WORD_W-1:0]  res_word;

  assign pulse    = s_tdata[PULSE_W-1:0];
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  ookd_classify u_cls_pulse (.pulse(pulse),                .cfg(cfg), .cls(cls_pulse));
  ookd_classify u_cls_first (.pulse(first_preamble_pulse), .cfg(cfg), .cls(cls_first));
  ookd_classify u_cls_g0    (.pulse(group_pulses[0]),      .cfg(cfg), .cls(cls_g0));
  ookd_classify u_cls_g1    (.pulse(group_pulses[1]),      .cfg(cfg), .cls(cls_g1));
  ookd_classify u_cls_g2    (.pulse(group_pulses[2]),      .cfg(cfg), .cls(cls_g2));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_min    <= RST_SHORT_MIN;
      cfg.short_max    <= RST_SHORT_MAX;
      cfg.long_min     <= RST_LONG_MIN;
      cfg.long_max     <= RST_LONG_MAX;
      cfg.preamble_min <= RST_PREAMBLE_MIN;
      cfg.preamble_max <= RST_PREAMBLE_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_MIN:    cfg.short_min    <= cfg_wdata;
        REG_SHORT_MAX:    cfg.short_max    <= cfg_wdata;
        REG_LONG_MIN:     cfg.long_min     <= cfg_wdata;
        REG_LONG_MAX:     cfg.long_max     <= cfg_wdata;
        REG_PREAMBLE_MIN: cfg.preamble_min <= cfg_wdata;
        REG_PREAMBLE_MAX: cfg.preamble_max <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign j   = pulse_count - CNT_W'(PREAMBLE_PULSES);
  assign pos = j[1:0];
  assign grp = j[CNT_W-1:2];

  assign bit_one  = cls_g0.in_short && cls_g1.is_long && cls_g2.in_short &&
                    cls_pulse.in_short;
  assign bit_zero = cls_g0.in_short && cls_g1.in_short && cls_g2.in_short &&
                    cls_pulse.is_long;

  always_comb begin
    pulse_count_next          = pulse_count;
    first_preamble_pulse_next = first_preamble_pulse;
    preamble_ok_next          = preamble_ok;
    group_pulses_next         = group_pulses;
    bit_shift_next            = bit_shift;
    snapshot_32_next          = snapshot_32;
    first_bad_group_next      = first_bad_group;

    if (pulse_count == '0) begin
      first_preamble_pulse_next = pulse;
    end else if (pulse_count == CNT_W'(1)) begin
      preamble_ok_next = cls_first.in_short && cls_pulse.is_preamble;
    end else if (pulse_count < CNT_W'(MAX_PULSES)) begin
      if (grp < GRP_W'(BITS_DIM)) begin
        if (pos != 2'd3) begin
          group_pulses_next[pos] = pulse;
        end else begin
          bit_shift_next = {bit_shift[WORD_W-2:0], bit_one};
          if (!bit_one && !bit_zero && first_bad_group == NO_BAD_GROUP) begin
            first_bad_group_next = grp[BAD_W-1:0];
          end
          if (grp == GRP_W'(BITS_PLAIN - 1)) begin
            snapshot_32_next = bit_shift_next[SNAP_W-1:0];
          end
        end
      end
    end

    if (pulse_count < CNT_W'(MAX_PULSES)) begin
      pulse_count_next = pulse_count + CNT_W'(1);
    end
  end

  always_comb begin
    n_bits   = (pulse_count_next - CNT_W'(MIN_TOTAL)) >> 2;
    res_ok   = 1'b0;
    res_dim  = 1'b0;
    res_word = '0;
    if (pulse_count_next < CNT_W'(MAX_PULSES) && pulse_count_next >= CNT_W'(MIN_TOTAL) &&
        preamble_ok_next) begin
      if (n_bits == CNT_W'(BITS_PLAIN) && first_bad_group_next >= BAD_W'(BITS_PLAIN)) begin
        res_ok   = 1'b1;
        res_word = WORD_W'(snapshot_32_next);
      end else if (n_bits == CNT_W'(BITS_DIM) &&
                   first_bad_group_next >= BAD_W'(BITS_DIM)) begin
        res_ok   = 1'b1;
        res_dim  = 1'b1;
        res_word = bit_shift_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s_accept && s_tlast)) begin
      pulse_count          <= '0;
      first_preamble_pulse <= '0;
      preamble_ok          <= 1'b0;
      group_pulses         <= '{default: '0};
      bit_shift            <= '0;
      snapshot_32          <= '0;
      first_bad_group      <= NO_BAD_GROUP;
    end else if (s_accept) begin
      pulse_count          <= pulse_count_next;
      first_preamble_pulse <= first_preamble_pulse_next;
      preamble_ok          <= preamble_ok_next;
      group_pulses         <= group_pulses_next;
      bit_shift            <= bit_shift_next;
      snapshot_32          <= snapshot_32_next;
      first_bad_group      <= first_bad_group_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && s_tlast) begin
      m_tdata <= {4'b0, res_word};
      m_tuser <= {res_dim, res_ok};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    pulse_count <= CNT_W'(MAX_PULSES))
    else $error("pulse count beyond saturation limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    s_accept && s_tlast |=> pulse_count == '0 && first_bad_group == NO_BAD_GROUP)
    else $error("frame state not cleared after last pulse");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
    else $error("rejected frame carries data");

  a_bad_group_range: assert property (@(posedge clk) disable iff (rst)
    first_bad_group == NO_BAD_GROUP || first_bad_group < BAD_W'(BITS_DIM))
    else $error("bad group index out of range");

endmodule

`default_nettype wire

/* tb/ook_pulse_frame_decoder_tb.sv */
// Self-checking testbench for the on-off-keyed pulse frame decoder.
module ook_pulse_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ookd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [PULSE_W-1:0] len;
    logic               last;
  } pulse_t;

  typedef struct packed {
    logic              accepted;
    logic              dim;
    logic [WORD_W-1:0] word;
  } frame_res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PULSE_W-1:0]   cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [39:0]          m_tdata;
  logic [1:0]           m_tuser;

  ook_pulse_frame_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  // decoder model state
  cfg_t               win;
  int unsigned        pulse_cnt;
  logic [PULSE_W-1:0] first_len;
  logic               pre_ok;
  logic [PULSE_W-1:0] grp_len [3];
  logic [WORD_W-1:0]  shift_word;
  logic [SNAP_W-1:0]  snap_word;
  logic [BAD_W-1:0]   bad_grp;

  pulse_t     pending_pulses[$];
  frame_res_t expected_frames[$];
  int         pulses_queued = 0;
  int         pulses_done = 0;
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  bit         pulse_taken = 1'b0;
  bit         frame_taken = 1'b0;
  pulse_t     next_pulse;
  frame_res_t got;
  frame_res_t want;

  function automatic bit in_win(input logic [PULSE_W-1:0] v, input logic [PULSE_W-1:0] lo,
                                input logic [PULSE_W-1:0] hi);
    return (lo <= v) && (v <= hi);
  endfunction

  task automatic clear_frame_model();
    pulse_cnt  = 0;
    first_len  = '0;
    pre_ok     = 1'b0;
    grp_len[0] = '0;
    grp_len[1] = '0;
    grp_len[2] = '0;
    shift_word = '0;
    snap_word  = '0;
    bad_grp    = NO_BAD_GROUP;
  endtask

  task automatic decode_pulse(input logic [PULSE_W-1:0] len, input logic last);
    int unsigned j;
    int unsigned g;
    int unsigned n;
    logic        one;
    logic        zero;
    frame_res_t  r;
    if (pulse_cnt == 0) begin
      first_len = len;
    end else if (pulse_cnt == 1) begin
      pre_ok = in_win(first_len, win.short_min, win.short_max) &&
               in_win(len, win.preamble_min, win.preamble_max);
    end else if (pulse_cnt < MAX_PULSES) begin
      j = pulse_cnt - PREAMBLE_PULSES;
      g = j >> 2;
      if (g < BITS_DIM) begin
        if ((j & 3) < 3) begin
          grp_len[j & 3] = len;
        end else begin
          one  = in_win(grp_len[0], win.short_min, win.short_max) &&
                 in_win(grp_len[1], win.long_min, win.long_max) &&
                 in_win(grp_len[2], win.short_min, win.short_max) &&
                 in_win(len, win.short_min, win.short_max);
          zero = in_win(grp_len[0], win.short_min, win.short_max) &&
                 in_win(grp_len[1], win.short_min, win.short_max) &&
                 in_win(grp_len[2], win.short_min, win.short_max) &&
                 in_win(len, win.long_min, win.long_max);
          shift_word = {shift_word[WORD_W-2:0], one};
          if (!one && !zero && bad_grp == NO_BAD_GROUP) bad_grp = BAD_W'(g);
          if (g == BITS_PLAIN - 1) snap_word = shift_word[SNAP_W-1:0];
        end
      end
    end
    if (pulse_cnt < MAX_PULSES) pulse_cnt++;
    if (last) begin
      r = '0;
      if (pulse_cnt < MAX_PULSES && pulse_cnt >= MIN_TOTAL && pre_ok) begin
        n = (pulse_cnt - MIN_TOTAL) >> 2;
        if (n == BITS_PLAIN && bad_grp >= BITS_PLAIN) begin
          r.accepted = 1'b1;
          r.word     = {{(WORD_W-SNAP_W){1'b0}}, snap_word};
        end else if (n == BITS_DIM && bad_grp >= BITS_DIM) begin
          r.accepted = 1'b1;
          r.dim      = 1'b1;
          r.word     = shift_word;
        end
      end
      expected_frames.push_back(r);
      clear_frame_model();
    end
  endtask

  // sample outputs, then inputs, at the rising edge
  always @(posedge clk) begin
    pulse_taken = 1'b0;
    frame_taken = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        frame_taken = 1'b1;
        got = '{accepted: m_tuser[0], dim: m_tuser[1], word: m_tdata[WORD_W-1:0]};
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t unexpected result: acc=%0b dim=%0b word=%09h",
                     $realtime, got.accepted, got.dim, got.word);
        end else begin
          want = expected_frames.pop_front();
          if (got.accepted !== want.accepted || got.dim !== want.dim ||
              got.word !== want.word) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t mismatch exp acc=%0b dim=%0b word=%09h got acc=%0b dim=%0b word=%09h",
                       $realtime, want.accepted, want.dim, want.word,
                       got.accepted, got.dim, got.word);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        pulse_taken = 1'b1;
        decode_pulse(s_tdata, s_tlast);
        pulses_done++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || pulse_taken || frame_taken) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL ook_pulse_frame_decoder");
        $finish;
      end
    end
  end

  // offer pulses; hold the current one until its transfer
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || pulse_taken) begin
      if (pending_pulses.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        next_pulse = pending_pulses.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_pulse.len;
        s_tlast  <= next_pulse.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PULSE_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SHORT_MIN:    win.short_min = val;
      REG_SHORT_MAX:    win.short_max = val;
      REG_LONG_MIN:     win.long_min = val;
      REG_LONG_MAX:     win.long_max = val;
      REG_PREAMBLE_MIN: win.preamble_min = val;
      REG_PREAMBLE_MAX: win.preamble_max = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_windows(input logic [PULSE_W-1:0] smin, input logic [PULSE_W-1:0] smax,
                             input logic [PULSE_W-1:0] lmin, input logic [PULSE_W-1:0] lmax,
                             input logic [PULSE_W-1:0] pmin, input logic [PULSE_W-1:0] pmax);
    write_reg(REG_SHORT_MIN, smin);
    write_reg(REG_SHORT_MAX, smax);
    write_reg(REG_LONG_MIN, lmin);
    write_reg(REG_LONG_MAX, lmax);
    write_reg(REG_PREAMBLE_MIN, pmin);
    write_reg(REG_PREAMBLE_MAX, pmax);
  endtask

  function automatic logic [PULSE_W-1:0] pick(input logic [PULSE_W-1:0] lo,
                                              input logic [PULSE_W-1:0] hi);
    if (lo <= hi) return PULSE_W'($urandom_range(hi, lo));
    return PULSE_W'($urandom_range(255, 0));
  endfunction

  function automatic logic [PULSE_W-1:0] off_class(input logic [PULSE_W-1:0] lo,
                                                   input logic [PULSE_W-1:0] hi);
    if (lo > hi) return PULSE_W'($urandom_range(255, 0));
    if (hi != 8'hFF) return hi + 8'd1;
    if (lo != 8'h00) return lo - 8'd1;
    return PULSE_W'($urandom_range(255, 0));
  endfunction

  task automatic push_pulse(input logic [PULSE_W-1:0] len, input logic last);
    pending_pulses.push_back('{len: len, last: last});
    pulses_queued++;
  endtask

  task automatic queue_noise(input int n);
    for (int k = 0; k < n; k++) push_pulse(PULSE_W'($urandom_range(255, 0)), k == n - 1);
  endtask

  // preamble, nbits groups, tail pulses; optional flaws in the first pulse,
  // the preamble gap or the leading pulse of one group
  task automatic queue_frame(input int nbits, input logic [WORD_W-1:0] bits, input int tail,
                             input bit bad_first, input bit bad_pre, input int bad_at);
    logic [PULSE_W-1:0] lens[$];
    logic [PULSE_W-1:0] s0;
    lens.push_back(bad_first ? off_class(win.short_min, win.short_max)
                             : pick(win.short_min, win.short_max));
    lens.push_back(bad_pre ? off_class(win.preamble_min, win.preamble_max)
                           : pick(win.preamble_min, win.preamble_max));
    for (int g = 0; g < nbits; g++) begin
      s0 = (g == bad_at) ? off_class(win.short_min, win.short_max)
                         : pick(win.short_min, win.short_max);
      lens.push_back(s0);
      if (bits[g % WORD_W]) begin
        lens.push_back(pick(win.long_min, win.long_max));
        lens.push_back(pick(win.short_min, win.short_max));
        lens.push_back(pick(win.short_min, win.short_max));
      end else begin
        lens.push_back(pick(win.short_min, win.short_max));
        lens.push_back(pick(win.short_min, win.short_max));
        lens.push_back(pick(win.long_min, win.long_max));
      end
    end
    for (int k = 0; k < tail; k++) lens.push_back(PULSE_W'($urandom_range(255, 0)));
    foreach (lens[k]) push_pulse(lens[k], k == lens.size() - 1);
  endtask

  task automatic queue_random(input int budget);
    int start;
    int r;
    int nb;
    int flaw_at;
    start = pulses_queued;
    while (pulses_queued - start < budget) begin
      r = $urandom_range(99, 0);
      if (r < 55) begin
        nb = $urandom_range(1, 0) ? BITS_PLAIN : BITS_DIM;
        flaw_at = -1;
        if ($urandom_range(4, 0) == 0) flaw_at = $urandom_range(nb - 1, 0);
        queue_frame(nb, WORD_W'({$urandom, $urandom}), $urandom_range(5, 2),
                    $urandom_range(19, 0) == 0, $urandom_range(19, 0) == 0, flaw_at);
      end else if (r < 80) begin
        queue_noise($urandom_range(12, 1));
      end else begin
        queue_frame($urandom_range(40, 0), WORD_W'({$urandom, $urandom}),
                    $urandom_range(5, 0), 1'b0, 1'b0, -1);
      end
    end
  endtask

  task automatic drain();
    while (pulses_done != pulses_queued || expected_frames.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    win = '{short_min: RST_SHORT_MIN, short_max: RST_SHORT_MAX,
            long_min: RST_LONG_MIN, long_max: RST_LONG_MAX,
            preamble_min: RST_PREAMBLE_MIN, preamble_max: RST_PREAMBLE_MAX};
    clear_frame_model();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // reset windows, no idling
    push_pulse(8'h00, 1'b1);
    push_pulse(8'hFF, 1'b0);
    push_pulse(8'hFF, 1'b1);
    queue_frame(0, '0, 1, 1'b0, 1'b0, -1);
    queue_frame(0, '0, 2, 1'b0, 1'b0, -1);
    queue_frame(BITS_PLAIN, '1, 5, 1'b0, 1'b0, -1);
    queue_frame(BITS_DIM, WORD_W'({$urandom, $urandom}), 3, 1'b0, 1'b0, -1);
    queue_frame(BITS_DIM, WORD_W'({$urandom, $urandom}), 2, 1'b0, 1'b0, 35);
    queue_frame(127, WORD_W'({$urandom, $urandom}), 1, 1'b0, 1'b0, -1);
    drain();

    // shifted windows, sender idling; spare indexes must be ignored
    set_windows(8'd1, 8'd9, 8'd12, 8'd40, 8'd50, 8'd90);
    write_reg(REG_SPARE_6, 8'hFF);
    write_reg(REG_SPARE_7, 8'h00);
    send_idle_pct = 52;
    queue_random(80);
    drain();

    // widest windows, receiver stalling plus one long hold-off
    set_windows(8'd0, 8'd10, 8'd11, 8'd255, 8'd0, 8'd255);
    send_idle_pct  = 0;
    recv_stall_pct = 52;
    hold_req = 1'b1;
    for (int k = 0; k < 20; k++) queue_noise(1);
    queue_random(80);
    drain();

    // overlapping short and long windows: a group fitting both decodes to 1
    set_windows(8'd0, 8'd30, 8'd10, 8'd40, 8'd200, 8'd255);
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    push_pulse(8'd20, 1'b0);
    push_pulse(8'd220, 1'b0);
    for (int k = 0; k < 4 * BITS_PLAIN + 2; k++) push_pulse(8'd20, k == 4 * BITS_PLAIN + 1);
    queue_random(80);
    drain();

    // empty long window: every group fails
    set_windows(8'd3, 8'd200, 8'd255, 8'd0, 8'd0, 8'd2);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random(80);
    drain();

    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("PASS ook_pulse_frame_decoder");
    end else begin
      $display("FAIL ook_pulse_frame_decoder");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/ookd_pkg.sv
hdl/ookd_classify.sv
hdl/ook_pulse_frame_decoder.sv
tb/ook_pulse_frame_decoder_tb.sv
